// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the grid path search RTL.
// No dependencies; included by modules that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every clock edge out of reset.
`define GAPS_CHECK(lbl, ck, rst_n, expr, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (expr)) else $error(msg);

// Condition in one cycle implies another in the next cycle.
`define GAPS_CHECK_NEXT(lbl, ck, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/gaps_pkg.sv =====
// Types, constants and helper functions of the grid path search block.
// No dependencies; used by gaps_engine and grid_astar_path_search.
package gaps_pkg;

	localparam int MAX_SIDE = 64;
	localparam int SIDE_W   = $clog2(MAX_SIDE);
	localparam int CELLS    = MAX_SIDE * MAX_SIDE;
	localparam int CELL_W   = 2 * SIDE_W;
	localparam int CNT_W    = CELL_W + 1;
	localparam int DIM_W    = SIDE_W + 1;
	localparam int G_W      = 16;
	localparam int H_W      = 11;
	localparam int F_W      = G_W + 1;

	localparam logic [4:0] COST_STRAIGHT = 5'd10;
	localparam logic [4:0] COST_DIAGONAL = 5'd14;

	localparam logic [1:0] MARK_NONE   = 2'd0;
	localparam logic [1:0] MARK_OPEN   = 2'd1;
	localparam logic [1:0] MARK_CLOSED = 2'd2;

	localparam logic [1:0] KIND_WRITE  = 2'd0;
	localparam logic [1:0] KIND_SEARCH = 2'd1;
	localparam logic [1:0] KIND_READ   = 2'd2;
	localparam logic [1:0] KIND_SPARE  = 2'd3;

	localparam logic [1:0] STATUS_OK      = 2'd0;
	localparam logic [1:0] STATUS_NOPATH  = 2'd1;
	localparam logic [1:0] STATUS_OUTSIDE = 2'd2;
	localparam logic [1:0] STATUS_STEP    = 2'd3;

	localparam logic REG_WIDTH  = 1'b0;
	localparam logic REG_HEIGHT = 1'b1;

	typedef struct packed {
		logic [1:0]        kind;
		logic [SIDE_W-1:0] col;
		logic [SIDE_W-1:0] row;
		logic              walkable;
		logic [SIDE_W-1:0] goal_col;
		logic [SIDE_W-1:0] goal_row;
		logic [CELL_W-1:0] step_index;
	} gaps_cmd_t;

	typedef struct packed {
		logic [1:0]        status;
		logic [CELL_W-1:0] path_length;
		logic [SIDE_W-1:0] out_col;
		logic [SIDE_W-1:0] out_row;
	} gaps_res_t;

	// One word of the node store
	typedef struct packed {
		logic [1:0]     mark;
		logic [G_W-1:0] g;
		logic [2:0]     par;
	} gaps_node_t;

	typedef enum logic [4:0] {
		ST_INIT, ST_IDLE, ST_WCELL, ST_CLEAR, ST_SEED, ST_LOOP,
		ST_SEL_RD, ST_SEL_NODE, ST_SEL_CMP, ST_SHF_RD, ST_SHF_WR,
		ST_EXPAND, ST_NB_RD, ST_NB_EVAL, ST_TRC_CHK, ST_TRC_EVAL,
		ST_STEP_RD, ST_STEP_OUT, ST_DONE
	} gaps_state_t;

	// Column offset of a move, sign extended to 8 bits
	function automatic logic [7:0] move_dc(input logic [2:0] k);
		logic [7:0] d;
		case (k) inside
			[3'd0:3'd2]: d = 8'hFF;
			[3'd3:3'd4]: d = 8'h00;
			default:     d = 8'h01;
		endcase
		return d;
	endfunction

	function automatic logic [7:0] move_dr(input logic [2:0] k);
		logic [7:0] d;
		case (k) inside
			3'd0, 3'd3, 3'd5: d = 8'hFF;
			3'd1, 3'd6:       d = 8'h00;
			default:          d = 8'h01;
		endcase
		return d;
	endfunction

	function automatic logic [4:0] move_cost(input logic [2:0] k);
		logic [4:0] c;
		case (k) inside
			3'd0, 3'd2, 3'd5, 3'd7: c = COST_DIAGONAL;
			default:                c = COST_STRAIGHT;
		endcase
		return c;
	endfunction

	function automatic logic [SIDE_W-1:0] absdiff(input logic [SIDE_W-1:0] a,
			input logic [SIDE_W-1:0] b);
		return (a > b) ? a - b : b - a;
	endfunction

	// 10 x Manhattan distance
	function automatic logic [H_W-1:0] heur(input logic [CELL_W-1:0] pos,
			input logic [SIDE_W-1:0] gc, input logic [SIDE_W-1:0] gr);
		logic [SIDE_W:0] d;
		d = {1'b0, absdiff(pos[SIDE_W-1:0], gc)} + {1'b0, absdiff(pos[CELL_W-1:SIDE_W], gr)};
		return H_W'({d, 3'b000}) + H_W'({d, 1'b0});
	endfunction

endpackage

// ===== rtl/core/gaps_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
module gaps_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;
endmodule

// ===== rtl/core/gaps_engine.sv =====
// Search sequencer: walkability, node, open list and path memories plus the FSM.
// Depends on gaps_pkg, gaps_ram and assert_macros.svh.
`include "assert_macros.svh"
module gaps_engine (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic [gaps_pkg::DIM_W-1:0]          grid_w,
	input  logic [gaps_pkg::DIM_W-1:0]          grid_h,
	input  logic                                cmd_valid,
	output logic                                cmd_ready,
	input  gaps_pkg::gaps_cmd_t                 cmd,
	output logic                                res_valid,
	input  logic                                res_ready,
	output gaps_pkg::gaps_res_t                 res
);
	import gaps_pkg::*;

	gaps_state_t state_q, state_d;

	gaps_cmd_t         cmd_q;
	logic [CNT_W-1:0]  i_q, cnt_q, best_idx_q, len_q, stored_len_q;
	logic [F_W-1:0]    best_f_q;
	logic [CELL_W-1:0] best_cell_q, scan_cell_q, nb_q, trace_n_q;
	logic [G_W-1:0]    best_g_q;
	logic [2:0]        best_par_q, k_q;
	logic [1:0]        res_status_q;
	logic [SIDE_W-1:0] res_col_q, res_row_q;

	// memory ports
	logic              walk_we, walk_wdata, walk_rd;
	logic [CELL_W-1:0] walk_waddr, walk_raddr;
	logic              node_we;
	logic [CELL_W-1:0] node_waddr, node_raddr;
	gaps_node_t        node_wdata, node_rd;
	logic              open_we;
	logic [CELL_W-1:0] open_waddr, open_raddr, open_wdata, open_rd;
	logic              path_we;
	logic [CELL_W-1:0] path_waddr, path_raddr, path_wdata, path_rd;

	gaps_ram #(.WIDTH(1), .DEPTH(CELLS)) u_walk (
		.clk(clk), .we(walk_we), .waddr(walk_waddr), .wdata(walk_wdata),
		.raddr(walk_raddr), .rdata(walk_rd)
	);
	gaps_ram #(.WIDTH($bits(gaps_node_t)), .DEPTH(CELLS)) u_node (
		.clk(clk), .we(node_we), .waddr(node_waddr), .wdata(node_wdata),
		.raddr(node_raddr), .rdata(node_rd)
	);
	gaps_ram #(.WIDTH(CELL_W), .DEPTH(CELLS)) u_open (
		.clk(clk), .we(open_we), .waddr(open_waddr), .wdata(open_wdata),
		.raddr(open_raddr), .rdata(open_rd)
	);
	gaps_ram #(.WIDTH(CELL_W), .DEPTH(CELLS)) u_path (
		.clk(clk), .we(path_we), .waddr(path_waddr), .wdata(path_wdata),
		.raddr(path_raddr), .rdata(path_rd)
	);

	// command decode
	logic [CELL_W-1:0] start_cell, goal_cell;
	logic              in_start, in_cmd_start, in_cmd_goal, sweep_last;
	assign start_cell   = {cmd_q.row, cmd_q.col};
	assign goal_cell    = {cmd_q.goal_row, cmd_q.goal_col};
	assign in_start     = ({1'b0, cmd_q.col} < grid_w) && ({1'b0, cmd_q.row} < grid_h);
	assign in_cmd_start = ({1'b0, cmd.col} < grid_w) && ({1'b0, cmd.row} < grid_h);
	assign in_cmd_goal  = ({1'b0, cmd.goal_col} < grid_w) && ({1'b0, cmd.goal_row} < grid_h);
	assign sweep_last   = (i_q[CELL_W-1:0] == CELL_W'(CELLS - 1));

	// open list scan
	logic [F_W-1:0]   f_scan;
	logic             best_upd, scan_more, shf_more;
	logic [CNT_W-1:0] i_inc;
	assign i_inc     = i_q + CNT_W'(1);
	assign f_scan    = {1'b0, node_rd.g} + F_W'(heur(scan_cell_q, cmd_q.goal_col, cmd_q.goal_row));
	assign best_upd  = (i_q == '0) || (f_scan < best_f_q);
	assign scan_more = (i_inc < cnt_q);
	assign shf_more  = (i_inc < cnt_q);

	// neighbor of the expanded node
	logic [7:0]        nc, nr;
	logic              nb_ok;
	logic [CELL_W-1:0] nb_cell;
	logic [G_W:0]      g_sum;
	logic [G_W-1:0]    g_new;
	logic              nb_open_better, nb_insert, nb_usable;
	assign nc      = {2'b00, best_cell_q[SIDE_W-1:0]} + move_dc(k_q);
	assign nr      = {2'b00, best_cell_q[CELL_W-1:SIDE_W]} + move_dr(k_q);
	assign nb_ok   = !nc[7] && !nr[7] && (nc[DIM_W-1:0] < grid_w) && (nr[DIM_W-1:0] < grid_h);
	assign nb_cell = {nr[SIDE_W-1:0], nc[SIDE_W-1:0]};
	assign g_sum   = {1'b0, best_g_q} + (G_W+1)'(move_cost(k_q));
	assign g_new   = g_sum[G_W] ? '1 : g_sum[G_W-1:0];
	assign nb_usable      = walk_rd && (node_rd.mark != MARK_CLOSED);
	assign nb_open_better = nb_usable && (node_rd.mark == MARK_OPEN) && (g_new < node_rd.g);
	assign nb_insert      = nb_usable && (node_rd.mark == MARK_NONE) && (cnt_q < CNT_W'(CELLS));

	// path trace: step back against the parent move
	logic [7:0]        pc, pr;
	logic              par_out, trc_stop;
	assign pc       = {2'b00, trace_n_q[SIDE_W-1:0]} - move_dc(node_rd.par);
	assign pr       = {2'b00, trace_n_q[CELL_W-1:SIDE_W]} - move_dr(node_rd.par);
	assign par_out  = (pc[7:SIDE_W] != '0) || (pr[7:SIDE_W] != '0);
	assign trc_stop = (trace_n_q == start_cell) || (len_q == CNT_W'(CELLS));

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_INIT:     if (sweep_last) state_d = ST_IDLE;
			ST_IDLE: begin
				if (cmd_valid) begin
					case (cmd.kind)
						KIND_WRITE:  state_d = ST_WCELL;
						KIND_SEARCH: state_d = (in_cmd_start && in_cmd_goal) ? ST_CLEAR : ST_DONE;
						KIND_READ:   state_d = ST_STEP_RD;
						default:     state_d = ST_DONE;
					endcase
				end
			end
			ST_WCELL:    state_d = ST_DONE;
			ST_CLEAR:    if (sweep_last) state_d = ST_SEED;
			ST_SEED:     state_d = ST_LOOP;
			ST_LOOP:     state_d = (cnt_q == '0) ? ST_DONE : ST_SEL_RD;
			ST_SEL_RD:   state_d = ST_SEL_NODE;
			ST_SEL_NODE: state_d = ST_SEL_CMP;
			ST_SEL_CMP:  state_d = scan_more ? ST_SEL_RD : ST_SHF_RD;
			ST_SHF_RD:   state_d = shf_more ? ST_SHF_WR : ST_EXPAND;
			ST_SHF_WR:   state_d = ST_SHF_RD;
			ST_EXPAND:   state_d = (best_cell_q == goal_cell) ? ST_TRC_CHK : ST_NB_RD;
			ST_NB_RD: begin
				if (nb_ok) state_d = ST_NB_EVAL;
				else if (k_q == 3'd7) state_d = ST_LOOP;
			end
			ST_NB_EVAL:  state_d = (k_q == 3'd7) ? ST_LOOP : ST_NB_RD;
			ST_TRC_CHK:  state_d = trc_stop ? ST_DONE : ST_TRC_EVAL;
			ST_TRC_EVAL: state_d = par_out ? ST_DONE : ST_TRC_CHK;
			ST_STEP_RD:  state_d = ({1'b0, cmd_q.step_index} >= stored_len_q) ? ST_DONE : ST_STEP_OUT;
			ST_STEP_OUT: state_d = ST_DONE;
			ST_DONE:     if (res_ready) state_d = ST_IDLE;
			default:     state_d = ST_INIT;
		endcase
	end

	// memory controls and handshake outputs
	always_comb begin
		walk_we    = 1'b0;
		walk_waddr = i_q[CELL_W-1:0];
		walk_wdata = 1'b1;
		walk_raddr = nb_cell;
		node_we    = 1'b0;
		node_waddr = i_q[CELL_W-1:0];
		node_wdata = '0;
		node_raddr = nb_cell;
		open_we    = 1'b0;
		open_waddr = i_q[CELL_W-1:0];
		open_wdata = open_rd;
		open_raddr = i_q[CELL_W-1:0];
		path_we    = 1'b0;
		path_waddr = len_q[CELL_W-1:0];
		path_wdata = trace_n_q;
		path_raddr = cmd_q.step_index;
		cmd_ready  = (state_q == ST_IDLE);
		res_valid  = (state_q == ST_DONE);
		case (state_q)
			ST_INIT:  walk_we = 1'b1;
			ST_WCELL: begin
				walk_we    = in_start;
				walk_waddr = start_cell;
				walk_wdata = cmd_q.walkable;
			end
			ST_CLEAR: node_we = 1'b1;
			ST_SEED: begin
				node_we    = 1'b1;
				node_waddr = start_cell;
				node_wdata = '{mark: MARK_OPEN, g: '0, par: '0};
				open_we    = 1'b1;
				open_waddr = '0;
				open_wdata = start_cell;
			end
			ST_SEL_NODE: node_raddr = open_rd;
			ST_SHF_RD:   open_raddr = i_inc[CELL_W-1:0];
			ST_SHF_WR:   open_we = 1'b1;
			ST_EXPAND: begin
				node_we    = 1'b1;
				node_waddr = best_cell_q;
				node_wdata = '{mark: MARK_CLOSED, g: best_g_q, par: best_par_q};
			end
			ST_NB_EVAL: begin
				node_we    = nb_open_better || nb_insert;
				node_waddr = nb_q;
				node_wdata = '{mark: MARK_OPEN, g: g_new, par: k_q};
				open_we    = nb_insert;
				open_waddr = cnt_q[CELL_W-1:0];
				open_wdata = nb_q;
			end
			ST_TRC_CHK:  node_raddr = trace_n_q;
			ST_TRC_EVAL: path_we = 1'b1;
			default: ;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_INIT;
			i_q          <= '0;
			cnt_q        <= '0;
			stored_len_q <= '0;
		end else begin
			state_q <= state_d;
			case (state_q)
				ST_INIT, ST_CLEAR, ST_SHF_WR: i_q <= i_inc;
				ST_IDLE, ST_LOOP:             i_q <= '0;
				ST_SEL_CMP: begin
					if (scan_more) i_q <= i_inc;
					else if (!best_upd) i_q <= best_idx_q;
				end
				default: ;
			endcase
			case (state_q)
				ST_SEED:    cnt_q <= CNT_W'(1);
				ST_SHF_RD:  if (!shf_more) cnt_q <= cnt_q - CNT_W'(1);
				ST_NB_EVAL: if (nb_insert) cnt_q <= cnt_q + CNT_W'(1);
				ST_LOOP:    if (cnt_q == '0) stored_len_q <= '0;
				ST_TRC_CHK: if (trc_stop) stored_len_q <= len_q;
				ST_TRC_EVAL: if (par_out) stored_len_q <= len_q + CNT_W'(1);
				default: ;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				cmd_q        <= cmd;
				res_status_q <= (cmd.kind == KIND_SEARCH && !(in_cmd_start && in_cmd_goal)) ?
					STATUS_OUTSIDE : STATUS_OK;
				res_col_q    <= '0;
				res_row_q    <= '0;
			end
			ST_WCELL:    if (!in_start) res_status_q <= STATUS_OUTSIDE;
			ST_LOOP:     if (cnt_q == '0) res_status_q <= STATUS_NOPATH;
			ST_SEL_NODE: scan_cell_q <= open_rd;
			ST_SEL_CMP: begin
				if (best_upd) begin
					best_f_q    <= f_scan;
					best_idx_q  <= i_q;
					best_cell_q <= scan_cell_q;
					best_g_q    <= node_rd.g;
					best_par_q  <= node_rd.par;
				end
			end
			ST_EXPAND: begin
				k_q       <= '0;
				trace_n_q <= best_cell_q;
				len_q     <= '0;
			end
			ST_NB_RD: begin
				nb_q <= nb_cell;
				if (!nb_ok) k_q <= k_q + 3'd1;
			end
			ST_NB_EVAL: k_q <= k_q + 3'd1;
			ST_TRC_EVAL: begin
				len_q     <= len_q + CNT_W'(1);
				trace_n_q <= {pr[SIDE_W-1:0], pc[SIDE_W-1:0]};
			end
			ST_STEP_RD:
				if ({1'b0, cmd_q.step_index} >= stored_len_q) res_status_q <= STATUS_STEP;
			ST_STEP_OUT: begin
				res_col_q <= path_rd[SIDE_W-1:0];
				res_row_q <= path_rd[CELL_W-1:SIDE_W];
			end
			default: ;
		endcase
	end

	assign res.status      = res_status_q;
	assign res.path_length = stored_len_q[CELL_W] ? '1 : stored_len_q[CELL_W-1:0];
	assign res.out_col     = res_col_q;
	assign res.out_row     = res_row_q;

	`GAPS_CHECK(a_cnt_max, clk, arst_n, cnt_q <= CNT_W'(CELLS), "open list count past capacity")
	`GAPS_CHECK(a_len_max, clk, arst_n, stored_len_q <= CNT_W'(CELLS), "stored path too long")
	`GAPS_CHECK(a_scan_idx, clk, arst_n, (state_q != ST_SEL_CMP) || (i_q < cnt_q), "scan past open list")
	`GAPS_CHECK_NEXT(a_res_idle, clk, arst_n, res_valid && res_ready, state_q == ST_IDLE, "no return to idle")
	`GAPS_CHECK_NEXT(a_nopath, clk, arst_n, (state_q == ST_LOOP) && (cnt_q == '0), res_valid && (res.status == STATUS_NOPATH), "empty open list not reported")
endmodule

// ===== rtl/core/grid_astar_path_search.sv =====
// Top level of the grid path search: stream ports, size registers, result register.
// Depends on gaps_pkg and gaps_engine.
//
//  channel  | handshake                    | payload
//  s_axis   | s_axis_tvalid/s_axis_tready  | tuser kind, tdata command fields
//  m_axis   | m_axis_tvalid/m_axis_tready  | tuser status, tdata path_length/col/row
//  cfg      | cfg_valid/cfg_ready          | cfg_index, cfg_data
//
// After reset a pass over every cell marks it walkable; no command is taken meanwhile.
// A cell write goes through ST_WCELL, a path read through ST_STEP_RD and ST_STEP_OUT
// (ST_STEP_RD alone past the path end), then the result transfer. A search clears the
// node store, then per expansion scans each open entry, shifts the entries behind the
// best one down and evaluates up to eight neighbors; every memory read is registered.
// One command at a time; a new command is taken while a result waits at m_axis.
module grid_astar_path_search (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [39:0] s_axis_tdata,  // col, row, walkable, goal_col, goal_row, step_index
	input  logic [1:0]  s_axis_tuser,  // kind
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,  // path_length, out_col, out_row
	output logic [1:0]  m_axis_tuser,  // status
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [6:0]  cfg_data
);
	import gaps_pkg::*;

	logic [DIM_W-1:0] grid_w_q, grid_h_q, cfg_clamped;
	gaps_cmd_t        cmd;
	gaps_res_t        res;
	logic             res_valid, res_ready;
	logic             m_valid_q;
	gaps_res_t        m_res_q;

	assign cmd.kind       = s_axis_tuser;
	assign cmd.col        = s_axis_tdata[5:0];
	assign cmd.row        = s_axis_tdata[11:6];
	assign cmd.walkable   = s_axis_tdata[12];
	assign cmd.goal_col   = s_axis_tdata[18:13];
	assign cmd.goal_row   = s_axis_tdata[24:19];
	assign cmd.step_index = s_axis_tdata[36:25];

	assign cfg_ready   = 1'b1;
	assign cfg_clamped = (cfg_data == '0) ? DIM_W'(1) :
		(cfg_data > DIM_W'(MAX_SIDE)) ? DIM_W'(MAX_SIDE) : cfg_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_w_q <= DIM_W'(MAX_SIDE);
			grid_h_q <= DIM_W'(MAX_SIDE);
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == REG_WIDTH) grid_w_q <= cfg_clamped;
			if (cfg_index == REG_HEIGHT) grid_h_q <= cfg_clamped;
		end
	end

	gaps_engine u_engine (
		.clk(clk), .arst_n(arst_n), .grid_w(grid_w_q), .grid_h(grid_h_q),
		.cmd_valid(s_axis_tvalid), .cmd_ready(s_axis_tready), .cmd(cmd),
		.res_valid(res_valid), .res_ready(res_ready), .res(res)
	);

	assign res_ready = !m_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (res_ready) begin
			m_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) m_res_q <= res;
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tuser  = m_res_q.status;
	assign m_axis_tdata  = {m_res_q.out_row, m_res_q.out_col, m_res_q.path_length};
endmodule
